// ===== rtl/tlt_pkg.sv =====
// Shared types, constants and table functions for the toy language tokenizer.
package tlt_pkg;

  localparam int TYPE_W      = 6;
  localparam int VALUE_W     = 31;
  localparam int STATUS_W    = 3;
  localparam int KEYWORD_LEN = 7;
  localparam int KW_IDX_W    = $clog2(KEYWORD_LEN);
  localparam int KW_COUNT    = 15;

  localparam int NUMBER_BITS_DEF = 31;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Token kinds beyond the keywords.
  localparam logic [TYPE_W-1:0] OP_BASE = 6'd15;
  localparam logic [TYPE_W-1:0] T_NUM   = 6'd33;
  localparam logic [TYPE_W-1:0] T_ID    = 6'd34;
  localparam logic [TYPE_W-1:0] T_STR   = 6'd35;
  localparam logic [TYPE_W-1:0] T_END   = 6'd36;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OPEN_COM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OPEN_STR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  // Operator indexes.
  localparam logic [4:0] OP_LBRACE = 5'd0;
  localparam logic [4:0] OP_RBRACE = 5'd1;
  localparam logic [4:0] OP_SEMI   = 5'd2;
  localparam logic [4:0] OP_COMMA  = 5'd3;
  localparam logic [4:0] OP_COLON  = 5'd4;
  localparam logic [4:0] OP_ASSIGN = 5'd5;
  localparam logic [4:0] OP_LPAREN = 5'd6;
  localparam logic [4:0] OP_RPAREN = 5'd7;
  localparam logic [4:0] OP_EQ     = 5'd8;
  localparam logic [4:0] OP_LT     = 5'd9;
  localparam logic [4:0] OP_GT     = 5'd10;
  localparam logic [4:0] OP_LE     = 5'd11;
  localparam logic [4:0] OP_NE     = 5'd12;
  localparam logic [4:0] OP_GE     = 5'd13;
  localparam logic [4:0] OP_PLUS   = 5'd14;
  localparam logic [4:0] OP_MINUS  = 5'd15;
  localparam logic [4:0] OP_STAR   = 5'd16;
  localparam logic [4:0] OP_SLASH  = 5'd17;
  localparam logic [4:0] OP_NONE   = 5'd31;

  typedef logic [0:KEYWORD_LEN-1][7:0] kw_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   token_type;
    logic [VALUE_W-1:0]  token_value;
    logic [STATUS_W-1:0] status;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]   token_type;
    logic [VALUE_W-1:0]  token_value;
    logic [STATUS_W-1:0] status;
  } tok_t;

  // One or two tokens produced by a single input transaction.
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } tok_pair_t;

  function automatic tok_t make_tok(input logic [TYPE_W-1:0] ty,
                                    input logic [VALUE_W-1:0] val,
                                    input logic [STATUS_W-1:0] st);
    tok_t t;
    t.token_type  = ty;
    t.token_value = val;
    t.status      = st;
    return t;
  endfunction

  // Keyword text, first character in element 0, zero padded.
  function automatic kw_word_t kw_text(input logic [3:0] k);
    kw_word_t w;
    unique case (k)
      4'd0:    w = kw_word_t'("program");
      4'd1:    w = kw_word_t'({"int", 32'd0});
      4'd2:    w = kw_word_t'({"string", 8'd0});
      4'd3:    w = kw_word_t'("boolean");
      4'd4:    w = kw_word_t'({"false", 16'd0});
      4'd5:    w = kw_word_t'({"true", 24'd0});
      4'd6:    w = kw_word_t'({"and", 32'd0});
      4'd7:    w = kw_word_t'({"or", 40'd0});
      4'd8:    w = kw_word_t'({"not", 32'd0});
      4'd9:    w = kw_word_t'({"if", 40'd0});
      4'd10:   w = kw_word_t'({"else", 24'd0});
      4'd11:   w = kw_word_t'({"while", 16'd0});
      4'd12:   w = kw_word_t'({"break", 16'd0});
      4'd13:   w = kw_word_t'({"read", 24'd0});
      4'd14:   w = kw_word_t'({"write", 16'd0});
      default: w = '1;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    unique case (k)
      4'd0, 4'd3:                 n = 4'd7;
      4'd2:                       n = 4'd6;
      4'd4, 4'd11, 4'd12, 4'd14:  n = 4'd5;
      4'd5, 4'd10, 4'd13:         n = 4'd4;
      4'd1, 4'd6, 4'd8:           n = 4'd3;
      4'd7, 4'd9:                 n = 4'd2;
      default:                    n = 4'd0;
    endcase
    return n;
  endfunction

  // Operators that are complete after one character.
  function automatic logic [4:0] single_op(input logic [7:0] c);
    logic [4:0] op;
    unique case (c)
      "{":     op = OP_LBRACE;
      "}":     op = OP_RBRACE;
      ";":     op = OP_SEMI;
      ",":     op = OP_COMMA;
      ":":     op = OP_COLON;
      "(":     op = OP_LPAREN;
      ")":     op = OP_RPAREN;
      "+":     op = OP_PLUS;
      "-":     op = OP_MINUS;
      "*":     op = OP_STAR;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic tok_t op_tok(input logic [4:0] op);
    return make_tok(OP_BASE + TYPE_W'(op), VALUE_W'(op), ST_OK);
  endfunction

endpackage

// ===== rtl/tlt_lexer.sv =====
// Front end: classifies each character and runs the lexer state machine.
module tlt_lexer import tlt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_item_t  item,
  output logic      emit_valid,
  output tok_pair_t emit_pair
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_NUM     = 3'd2;
  localparam logic [2:0] MODE_STR     = 3'd3;
  localparam logic [2:0] MODE_COM     = 3'd4;
  localparam logic [2:0] MODE_COMSTAR = 3'd5;
  localparam logic [2:0] MODE_PEND    = 3'd6;

  localparam int PW = NUMBER_BITS + 4;

  logic [2:0]             mode, mode_next;
  kw_word_t               prefix, prefix_next;
  logic [3:0]             word_length, word_length_next;
  logic [NUMBER_BITS-1:0] acc, acc_next;
  logic                   ovf, ovf_next;
  logic [7:0]             pending, pending_next;
  logic [VALUE_W-1:0]     ident_count, ident_count_next;
  logic [VALUE_W-1:0]     string_count, string_count_next;

  logic       is_letter, is_digit, is_space;
  logic [3:0] dig;
  logic [4:0] sop;
  logic [2:0] idle_mode;
  logic       idle_emit;
  tok_t       idle_tok;
  logic       kw_hit;
  logic [3:0] kw_idx;
  tok_t       word_tok, num_tok, pend_tok;
  logic [PW-1:0] prod;
  logic       lead_v, tail_v, apply_idle, bump_ident;
  tok_t       lead_tok, tail_tok;

  // Character classes and the action of a character seen between tokens.
  always_comb begin
    is_letter = (item.ch >= "a" && item.ch <= "z") || (item.ch >= "A" && item.ch <= "Z");
    is_digit  = item.ch >= "0" && item.ch <= "9";
    is_space  = item.ch == " " || item.ch == "\n" || item.ch == "\t";
    dig       = 4'(item.ch - 8'h30);
    sop       = single_op(item.ch);
    idle_mode = MODE_IDLE;
    idle_emit = 1'b0;
    idle_tok  = make_tok(T_END, VALUE_W'(item.ch), ST_BAD_CHAR);
    priority if (is_space) begin
      idle_mode = MODE_IDLE;
    end else if (is_letter) begin
      idle_mode = MODE_WORD;
    end else if (is_digit) begin
      idle_mode = MODE_NUM;
    end else if (sop != OP_NONE) begin
      idle_emit = 1'b1;
      idle_tok  = op_tok(sop);
    end else if (item.ch == "/" || item.ch == "=" || item.ch == "<" ||
                 item.ch == ">" || item.ch == "!") begin
      idle_mode = MODE_PEND;
    end else if (item.ch == "\"") begin
      idle_mode = MODE_STR;
    end else begin
      idle_emit = 1'b1;
    end
  end

  // Keyword lookup: fifteen parallel compares.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 4'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (word_length == kw_len(4'(k)) && prefix == kw_text(4'(k))) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
    word_tok = kw_hit ? make_tok(TYPE_W'(kw_idx), VALUE_W'(kw_idx), ST_OK)
                      : make_tok(T_ID, ident_count, ST_OK);
    num_tok  = make_tok(T_NUM, VALUE_W'(acc), ovf ? ST_OVERFLOW : ST_OK);
    unique case (pending)
      "/":     pend_tok = op_tok(OP_SLASH);
      "=":     pend_tok = op_tok(OP_ASSIGN);
      "<":     pend_tok = op_tok(OP_LT);
      ">":     pend_tok = op_tok(OP_GT);
      default: pend_tok = make_tok(T_END, VALUE_W'(pending), ST_BAD_CHAR);
    endcase
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + PW'(dig);
  end

  // Main state machine.
  always_comb begin
    mode_next         = mode;
    prefix_next       = prefix;
    word_length_next  = word_length;
    acc_next          = acc;
    ovf_next          = ovf;
    pending_next      = pending;
    string_count_next = string_count;
    lead_v     = 1'b0;
    lead_tok   = word_tok;
    tail_v     = 1'b0;
    tail_tok   = idle_tok;
    apply_idle = 1'b0;
    bump_ident = 1'b0;

    if (item.is_end) begin
      tail_v    = 1'b1;
      tail_tok  = make_tok(T_END, '0, ST_OK);
      mode_next = MODE_IDLE;
      unique case (mode)
        MODE_WORD: begin
          lead_v     = 1'b1;
          bump_ident = !kw_hit;
        end
        MODE_NUM: begin
          lead_v   = 1'b1;
          lead_tok = num_tok;
        end
        MODE_PEND: begin
          lead_v   = 1'b1;
          lead_tok = pend_tok;
        end
        MODE_COM, MODE_COMSTAR: tail_tok.status = ST_OPEN_COM;
        MODE_STR:               tail_tok.status = ST_OPEN_STR;
        default: ;
      endcase
    end else begin
      unique case (mode)
        MODE_WORD: begin
          if (is_letter || is_digit) begin
            if (word_length < 4'(KEYWORD_LEN)) begin
              prefix_next[word_length[KW_IDX_W-1:0]] = item.ch;
            end
            if (word_length != 4'hF) begin
              word_length_next = word_length + 4'd1;
            end
          end else begin
            lead_v     = 1'b1;
            bump_ident = !kw_hit;
            apply_idle = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            if (prod[PW-1:NUMBER_BITS] != '0) begin
              acc_next = '1;
              ovf_next = 1'b1;
            end else begin
              acc_next = prod[NUMBER_BITS-1:0];
            end
          end else begin
            lead_v     = 1'b1;
            lead_tok   = num_tok;
            apply_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (item.ch == "\"") begin
            tail_v            = 1'b1;
            tail_tok          = make_tok(T_STR, string_count, ST_OK);
            string_count_next = string_count + 1'b1;
            mode_next         = MODE_IDLE;
          end
        end
        MODE_COM: begin
          if (item.ch == "*") begin
            mode_next = MODE_COMSTAR;
          end
        end
        MODE_COMSTAR: begin
          if (item.ch == "/") begin
            mode_next = MODE_IDLE;
          end else if (item.ch != "*") begin
            mode_next = MODE_COM;
          end
        end
        MODE_PEND: begin
          if (pending == "/" && item.ch == "*") begin
            mode_next = MODE_COM;
          end else if (item.ch == "=" && pending != "/") begin
            tail_v    = 1'b1;
            mode_next = MODE_IDLE;
            unique case (pending)
              "=":     tail_tok = op_tok(OP_EQ);
              "<":     tail_tok = op_tok(OP_LE);
              ">":     tail_tok = op_tok(OP_GE);
              default: tail_tok = op_tok(OP_NE);
            endcase
          end else begin
            lead_v     = 1'b1;
            lead_tok   = pend_tok;
            apply_idle = 1'b1;
          end
        end
        default: apply_idle = 1'b1;
      endcase
    end

    // The character that ended a token is lexed again from idle.
    if (apply_idle) begin
      mode_next = idle_mode;
      tail_v    = idle_emit;
      tail_tok  = idle_tok;
      if (idle_mode == MODE_WORD) begin
        prefix_next      = '0;
        prefix_next[0]   = item.ch;
        word_length_next = 4'd1;
      end
      if (idle_mode == MODE_NUM) begin
        acc_next = NUMBER_BITS'(dig);
        ovf_next = 1'b0;
      end
      if (idle_mode == MODE_PEND) begin
        pending_next = item.ch;
      end
    end

    ident_count_next = ident_count + VALUE_W'(bump_ident);

    emit_valid       = take && (lead_v || tail_v);
    emit_pair.two    = lead_v && tail_v;
    emit_pair.first  = lead_v ? lead_tok : tail_tok;
    emit_pair.second = tail_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      ident_count  <= '0;
      string_count <= '0;
    end else if (take) begin
      mode         <= mode_next;
      ident_count  <= ident_count_next;
      string_count <= string_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prefix      <= prefix_next;
      word_length <= word_length_next;
      acc         <= acc_next;
      ovf         <= ovf_next;
      pending     <= pending_next;
    end
  end

endmodule

// ===== rtl/tlt_queue.sv =====
// Short queue of token pairs between the lexer and the output stage.
module tlt_queue import tlt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  tok_pair_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output tok_pair_t rd_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  tok_pair_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W + 1)'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(wr_en) - (PTR_W + 1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("queue read while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en))
    else $error("queue write while full");

endmodule

// ===== rtl/tlt_emit.sv =====
// Back end: holds one token pair and hands its tokens out one at a time.
module tlt_emit import tlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  tok_pair_t q_data,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      hold_valid;
  logic      sel;
  tok_pair_t hold;
  tok_t      cur;
  logic      is_last;
  logic      load;

  assign is_last = !hold.two || sel;
  assign load    = !hold_valid || (pop && is_last);
  assign q_pop   = load && !q_empty;
  assign empty   = !hold_valid;
  assign cur     = sel ? hold.second : hold.first;

  always_comb begin
    out_item.token_type  = cur.token_type;
    out_item.token_value = cur.token_value;
    out_item.status      = cur.status;
    out_item.last_of_run = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (load) begin
      hold_valid <= !q_empty;
      sel        <= 1'b0;
    end else if (pop) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_data;
    end
  end

  a_second_only_in_pair: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && sel) |-> hold.two)
    else $error("second slot selected for a single token");

  a_pair_continues: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && pop && !is_last) |=> (hold_valid && sel))
    else $error("second token of a pair lost");

endmodule

// ===== rtl/toy_language_tokenizer_unit.sv =====
// Top level of the toy language tokenizer: lexer, token queue and output stage.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_item  (ch, is_end)
//   result    out        pop / empty          out_item (token_type, token_value,
//                                                       status, last_of_run)
//
// The block takes one character transaction per cycle while the token queue
// has room, and delivers one token transaction per cycle while pop is high
// and a token waits. A character that causes two tokens yields two result
// transactions, so the output port sets the sustained rate when tokens come
// in pairs. Each token passes the queue and then the output stage's hold
// register. Reset is synchronous; there is no clearing pass. Either side may
// stall for any time: the queue absorbs short bursts, full rises when it fills.
module toy_language_tokenizer_unit import tlt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  // The front end sees an input transaction only when the queue has a free
  // slot, which is a safe bound since a character makes at most one pair.
  logic      take;
  logic      lex_valid;
  tok_pair_t lex_pair;
  logic      q_empty;
  logic      q_pop;
  tok_pair_t q_data;

  assign take = push && !full;

  tlt_lexer #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_item),
    .emit_valid(lex_valid),
    .emit_pair (lex_pair)
  );

  // Decouples the lexer from the output side so that each stalls on its own.
  tlt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (lex_valid),
    .wr_data(lex_pair),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  // The output stage splits a pair into two result transactions and marks
  // the last token that each character produced.
  tlt_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

endmodule
